### hw/rtl/dsce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsce_pkg
// types, constants and helpers shared by the decimal string converter
// ----------------------------------------------------------------------------
package dsce_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [1:0]  kind;
    logic        negative;
    logic [63:0] coeff_high;
    logic [63:0] coeff_low;
    logic [31:0] exponent;
  } out_item_t;

  localparam logic [1:0] KIND_NORMAL = 2'd0;
  localparam logic [1:0] KIND_INF    = 2'd1;
  localparam logic [1:0] KIND_NAN    = 2'd2;

  localparam logic [3:0] TOK_START = 4'd0;
  localparam logic [3:0] TOK_INF   = 4'd3;
  localparam logic [3:0] TOK_PINF  = 4'd7;
  localparam logic [3:0] TOK_NINF  = 4'd11;
  localparam logic [3:0] TOK_NAN   = 4'd14;
  localparam logic [3:0] TOK_DEAD  = 4'd15;

  localparam logic [127:0] MAX128 = {128{1'b1}};
  localparam logic [127:0] LIM128 = MAX128 / 128'd10;

  // ceil(2^23 / 10): exact quotient by ten for numerators below 2^22
  localparam logic [19:0] RECIP10 = 20'd838861;

  // snapshot of a finished parse, handed to the back end
  typedef struct packed {
    logic [1:0]   kind;
    logic         special_neg;
    logic         error;
    logic         sign;
    logic [127:0] int_acc;
    logic [127:0] frac_acc;
    logic [31:0]  int_extra;
    logic [31:0]  frac_cnt;
    logic         exp_neg;
    logic [31:0]  exp_val;
  } job_t;

  typedef enum logic [2:0] {
    PH_WS, PH_MANT, PH_ESIGN, PH_EDIG, PH_DONE, PH_STOP
  } phase_e;

  typedef enum logic [2:0] {
    BK_IDLE, BK_SCALE, BK_FDIV, BK_MERGE, BK_FIX, BK_EXP, BK_OUT
  } back_e;

  function automatic logic [127:0] mul10(input logic [127:0] a);
    return {a[124:0], 3'b000} + {a[126:0], 1'b0};
  endfunction

  function automatic logic [3:0] tok_next(input logic [3:0] s, input logic [7:0] c);
    logic [7:0] l;
    logic [3:0] r;
    l = (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
    r = TOK_DEAD;
    case (s)
      4'd0: begin
        if (l == "i") r = 4'd1;
        else if (l == "+") r = 4'd4;
        else if (l == "-") r = 4'd8;
        else if (l == "n") r = 4'd12;
      end
      4'd1, 4'd5, 4'd9: if (l == "n") r = s + 4'd1;
      4'd2, 4'd6, 4'd10: if (l == "f") r = s + 4'd1;
      4'd4, 4'd8: if (l == "i") r = s + 4'd1;
      4'd12: if (l == "a") r = 4'd13;
      4'd13: if (l == "n") r = 4'd14;
      default: r = TOK_DEAD;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/dsce_div10.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsce_div10
// multi-cycle divide of a 128-bit value by ten, one 16-bit limb per cycle
// ----------------------------------------------------------------------------
module dsce_div10 (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [127:0] num_i,
  output logic         done_o,
  output logic [127:0] quo_o,
  output logic [3:0]   rem_o
);

  logic [127:0] q_q, q_d;
  logic [3:0]   r_q, r_d;
  logic [2:0]   cnt_q, cnt_d;
  logic         busy_q, busy_d;
  logic         done_q, done_d;

  always_comb begin
    logic [19:0] cur;
    logic [39:0] prod;
    logic [15:0] qd;
    q_d = q_q;
    r_d = r_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    // running remainder in front of the top limb, divided by reciprocal multiply
    cur = {r_q, q_q[127:112]};
    prod = 40'(cur) * 40'(dsce_pkg::RECIP10);
    qd = prod[38:23];
    if (start_i) begin
      q_d = num_i;
      r_d = 4'd0;
      cnt_d = 3'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      q_d = {q_q[111:0], qd};
      r_d = 4'(cur - 20'(qd) * 20'd10);
      cnt_d = cnt_q + 3'd1;
      if (cnt_q == 3'd7) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
    r_q <= r_d;
  end

  assign done_o = done_q;
  assign quo_o  = q_q;
  assign rem_o  = r_q;

endmodule

### hw/rtl/dsce_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsce_front
// per-character scanner: whitespace, sign, digits, exponent and special words
// ----------------------------------------------------------------------------
module dsce_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  dsce_pkg::in_item_t in_data_i,
  output logic              in_stall_o,
  output logic              job_valid_o,
  output dsce_pkg::job_t    job_o,
  input  logic              job_ready_i
);

  dsce_pkg::phase_e ph_q, ph_d;
  logic [127:0] ia_q, ia_d, fa_q, fa_d;
  logic [31:0]  ix_q, ix_d, fc_q, fc_d, ev_q, ev_d;
  logic         pt_q, pt_d, rd_q, rd_d, sg_q, sg_d, en_q, en_d, er_q, er_d;
  logic [3:0]   tk_q, tk_d;
  logic         acc;

  assign in_stall_o = in_data_i.end_of_string && !job_ready_i;
  assign acc = in_valid_i && !in_stall_o;

  always_comb begin
    logic [7:0] c;
    logic       dig, mant;
    logic [3:0] d;
    logic [127:0] x, lim;
    c = in_data_i.char_code;
    dig = c >= "0" && c <= "9";
    d = 4'(c - 8'h30);
    ph_d = ph_q; ia_d = ia_q; fa_d = fa_q; ix_d = ix_q; fc_d = fc_q; ev_d = ev_q;
    pt_d = pt_q; rd_d = rd_q; sg_d = sg_q; en_d = en_q; er_d = er_q; tk_d = tk_q;
    mant = 1'b0;
    x = 128'd0;
    lim = 128'd0;
    if (ph_q != dsce_pkg::PH_STOP) begin
      if (c == 8'd0) begin
        ph_d = dsce_pkg::PH_STOP;
      end else if (ph_q == dsce_pkg::PH_WS) begin
        if (!(c == 8'd32 || (c >= 8'd9 && c <= 8'd13))) begin
          tk_d = dsce_pkg::tok_next(dsce_pkg::TOK_START, c);
          ph_d = dsce_pkg::PH_MANT;
          if (c == "-") sg_d = 1'b1;
          else if (c != "+") mant = 1'b1;
        end
      end else begin
        tk_d = dsce_pkg::tok_next(tk_q, c);
        if (ph_q == dsce_pkg::PH_MANT) begin
          mant = 1'b1;
        end else if (ph_q == dsce_pkg::PH_ESIGN || ph_q == dsce_pkg::PH_EDIG) begin
          if (ph_q == dsce_pkg::PH_ESIGN && c == "-") begin
            en_d = 1'b1;
            ph_d = dsce_pkg::PH_EDIG;
          end else if (dig) begin
            ph_d = dsce_pkg::PH_EDIG;
            if (ev_q > (32'hFFFFFFFF - 32'(d)) / 32'd10) ev_d = 32'hFFFFFFFF;
            else ev_d = ev_q * 32'd10 + 32'(d);
          end else if (ph_q == dsce_pkg::PH_ESIGN && c == "+") begin
            ph_d = dsce_pkg::PH_EDIG;
          end else begin
            ph_d = dsce_pkg::PH_DONE;
          end
        end
      end
      if (mant) begin
        if (dig) begin
          x = pt_q ? fa_q : ia_q;
          // limit for digit d: (max - d) / 10 is LIM128 minus one when d > 5
          lim = (d > 4'd5) ? dsce_pkg::LIM128 - 128'd1 : dsce_pkg::LIM128;
          if (x > lim) begin
            if (!rd_q) begin
              if (d >= 4'd5 && x != dsce_pkg::MAX128) x = x + 128'd1;
              rd_d = 1'b1;
            end
            if (!pt_q && ix_q != 32'hFFFFFFFF) ix_d = ix_q + 32'd1;
          end else begin
            x = dsce_pkg::mul10(x) + 128'(d);
            if (pt_q && fc_q != 32'hFFFFFFFF) fc_d = fc_q + 32'd1;
          end
          if (pt_q) fa_d = x;
          else ia_d = x;
        end else if (c == ".") begin
          if (pt_q) begin
            er_d = 1'b1;
            ph_d = dsce_pkg::PH_DONE;
          end else pt_d = 1'b1;
        end else if (c == "e" || c == "E") begin
          ph_d = dsce_pkg::PH_ESIGN;
        end else begin
          ph_d = dsce_pkg::PH_DONE;
        end
      end
    end
  end

  always_comb begin
    job_o = '0;
    job_o.error = er_d;
    job_o.sign = sg_d;
    job_o.int_acc = ia_d;
    job_o.frac_acc = fa_d;
    job_o.int_extra = ix_d;
    job_o.frac_cnt = fc_d;
    job_o.exp_neg = en_d;
    job_o.exp_val = ev_d;
    job_o.kind = dsce_pkg::KIND_NORMAL;
    if (tk_d == dsce_pkg::TOK_INF || tk_d == dsce_pkg::TOK_PINF) begin
      job_o.kind = dsce_pkg::KIND_INF;
    end else if (tk_d == dsce_pkg::TOK_NINF) begin
      job_o.kind = dsce_pkg::KIND_INF;
      job_o.special_neg = 1'b1;
    end else if (tk_d == dsce_pkg::TOK_NAN) begin
      job_o.kind = dsce_pkg::KIND_NAN;
    end
  end

  assign job_valid_o = acc && in_data_i.end_of_string;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= dsce_pkg::PH_WS;
      ia_q <= '0; fa_q <= '0; ix_q <= '0; fc_q <= '0; ev_q <= '0;
      pt_q <= 1'b0; rd_q <= 1'b0; sg_q <= 1'b0; en_q <= 1'b0; er_q <= 1'b0;
      tk_q <= dsce_pkg::TOK_START;
    end else if (acc) begin
      if (in_data_i.end_of_string) begin
        ph_q <= dsce_pkg::PH_WS;
        ia_q <= '0; fa_q <= '0; ix_q <= '0; fc_q <= '0; ev_q <= '0;
        pt_q <= 1'b0; rd_q <= 1'b0; sg_q <= 1'b0; en_q <= 1'b0; er_q <= 1'b0;
        tk_q <= dsce_pkg::TOK_START;
      end else begin
        ph_q <= ph_d;
        ia_q <= ia_d; fa_q <= fa_d; ix_q <= ix_d; fc_q <= fc_d; ev_q <= ev_d;
        pt_q <= pt_d; rd_q <= rd_d; sg_q <= sg_d; en_q <= en_d; er_q <= er_d;
        tk_q <= tk_d;
      end
    end
  end

endmodule

### hw/rtl/dsce_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsce_queue
// two-entry job queue between scanner and number builder
// ----------------------------------------------------------------------------
module dsce_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dsce_pkg::job_t push_data_i,
  output logic           ready_o,
  output logic           pop_valid_o,
  output dsce_pkg::job_t pop_data_o,
  input  logic           pop_i
);

  dsce_pkg::job_t mem_q [2];
  logic           wp_q, rp_q;
  logic [1:0]     cnt_q;

  assign ready_o     = cnt_q != 2'd2;
  assign pop_valid_o = cnt_q != 2'd0;
  assign pop_data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop_i) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= push_data_i;
  end

endmodule

### hw/rtl/dsce_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsce_back
// aligns integer and fraction parts, merges them and applies the exponent; passes specials and errors on
// ----------------------------------------------------------------------------
module dsce_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  input  dsce_pkg::job_t     job_i,
  output logic               job_pop_o,
  output logic               out_valid_o,
  output dsce_pkg::out_item_t out_data_o,
  input  logic               out_stall_i
);

  dsce_pkg::back_e st_q, st_d;
  dsce_pkg::job_t  j_q;
  logic [127:0]    co_q, co_d, fr_q, fr_d, q1_q, q1_d;
  logic signed [34:0] e_q, e_d;
  logic [31:0]     k_q, k_d;
  logic [5:0]      dv_q, dv_d;
  logic            ph2_q, ph2_d;
  dsce_pkg::out_item_t o_q, o_d;
  logic            ov_q, ov_d;
  logic            dstart;
  logic [127:0]    dnum;
  logic            ddone;
  logic [127:0]    dquo;
  logic [3:0]      drem;

  dsce_div10 u_div (
    .clk_i, .rst_ni, .start_i(dstart), .num_i(dnum),
    .done_o(ddone), .quo_o(dquo), .rem_o(drem)
  );

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      dsce_pkg::BK_IDLE:
        if (job_valid_i) begin
          if (job_i.kind != dsce_pkg::KIND_NORMAL || job_i.error) st_d = dsce_pkg::BK_OUT;
          else if (job_i.int_acc != 128'd0) st_d = dsce_pkg::BK_SCALE;
          else st_d = dsce_pkg::BK_MERGE;
        end
      dsce_pkg::BK_SCALE:
        if (!(k_q < j_q.frac_cnt && co_q <= dsce_pkg::LIM128)) begin
          st_d = (k_q < j_q.frac_cnt) ? dsce_pkg::BK_FDIV : dsce_pkg::BK_MERGE;
        end
      dsce_pkg::BK_FDIV:
        if (dv_q == 6'd0 && !ph2_q) st_d = dsce_pkg::BK_MERGE;
        else if (ddone && dv_q == 6'd1) st_d = dsce_pkg::BK_MERGE;
      dsce_pkg::BK_MERGE:
        if (co_q + fr_q < co_q) st_d = dsce_pkg::BK_FIX;
        else st_d = dsce_pkg::BK_EXP;
      dsce_pkg::BK_FIX:
        if (ddone && ph2_q) st_d = dsce_pkg::BK_EXP;
      dsce_pkg::BK_EXP:
        st_d = dsce_pkg::BK_OUT;
      dsce_pkg::BK_OUT:
        if (!ov_q || !out_stall_i) st_d = dsce_pkg::BK_IDLE;
      default: st_d = dsce_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    logic signed [34:0] ee;
    job_pop_o = 1'b0;
    co_d = co_q; fr_d = fr_q; q1_d = q1_q; e_d = e_q; k_d = k_q;
    dv_d = dv_q; ph2_d = ph2_q; o_d = o_q; ov_d = ov_q;
    dstart = 1'b0;
    dnum = fr_q;
    ee = e_q;
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    unique case (st_q)
      dsce_pkg::BK_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          co_d = job_i.int_acc;
          fr_d = job_i.frac_acc;
          e_d = 35'($signed({3'b000, job_i.int_extra})) - 35'($signed({3'b000, job_i.frac_cnt}));
          k_d = 32'd0;
          ph2_d = 1'b0;
        end
      end
      dsce_pkg::BK_SCALE: begin
        if (k_q < j_q.frac_cnt && co_q <= dsce_pkg::LIM128) begin
          co_d = dsce_pkg::mul10(co_q);
          k_d = k_q + 32'd1;
        end else if (k_q < j_q.frac_cnt) begin
          e_d = e_q + 35'($signed({3'b000, j_q.frac_cnt - k_q}));
          // beyond 40 steps the fraction is already zero
          dv_d = (j_q.frac_cnt - k_q > 32'd40) ? 6'd40 : 6'(j_q.frac_cnt - k_q);
          ph2_d = 1'b0;
        end
      end
      dsce_pkg::BK_FDIV: begin
        if (!ph2_q && dv_q != 6'd0) begin
          dstart = 1'b1;
          dnum = fr_q;
          ph2_d = 1'b1;
        end else if (ddone) begin
          fr_d = dquo;
          dv_d = dv_q - 6'd1;
          ph2_d = 1'b0;
        end
      end
      dsce_pkg::BK_MERGE: begin
        if (co_q + fr_q < co_q) begin
          dstart = 1'b1;
          dnum = co_q;
          ph2_d = 1'b0;
        end else co_d = co_q + fr_q;
      end
      dsce_pkg::BK_FIX: begin
        if (ddone && !ph2_q) begin
          q1_d = dquo;
          dstart = 1'b1;
          dnum = fr_q + 128'(drem);
          ph2_d = 1'b1;
        end else if (ddone) begin
          co_d = q1_q + dquo;
          e_d = e_q + 35'sd1;
        end
      end
      dsce_pkg::BK_EXP: begin
        if (j_q.exp_neg) ee = e_q - 35'($signed({3'b000, j_q.exp_val}));
        else ee = e_q + 35'($signed({3'b000, j_q.exp_val}));
        if (ee > 35'sd2147483647) ee = 35'sd2147483647;
        if (ee < -35'sd2147483648) ee = -35'sd2147483648;
        e_d = ee;
      end
      dsce_pkg::BK_OUT: begin
        if (!ov_q || !out_stall_i) begin
          ov_d = 1'b1;
          o_d = '0;
          if (j_q.kind != dsce_pkg::KIND_NORMAL) begin
            o_d.kind = j_q.kind;
            o_d.negative = j_q.special_neg;
          end else if (j_q.error) begin
            o_d.status = 1'b1;
          end else begin
            o_d.negative = j_q.sign && (co_q != 128'd0);
            o_d.coeff_high = co_q[127:64];
            o_d.coeff_low = co_q[63:0];
            o_d.exponent = e_q[31:0];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= dsce_pkg::BK_IDLE;
      ov_q <= 1'b0;
      ph2_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ov_q <= ov_d;
      ph2_q <= ph2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) j_q <= job_i;
    co_q <= co_d; fr_q <= fr_d; q1_q <= q1_d; e_q <= e_d;
    k_q <= k_d; dv_q <= dv_d; o_q <= o_d;
  end

  assign out_valid_o = ov_q;
  assign out_data_o = o_q;

endmodule

### hw/rtl/decimal_string_to_coeff_exp_core.sv
`timescale 1ns / 1ps
// sequence: after the final beat the number builder runs up to 38 multiply-by-ten steps,
// up to 40 fraction divides by ten, a merge fix-up, then the output register
// throughput: one character per cycle; a two-deep job queue lets the next string scan
// while the builder works, and a final beat stalls only while that queue is full
// reset: asynchronous active low, scanner returns to whitespace skip, queue empty
// ----------------------------------------------------------------------------
// decimal_string_to_coeff_exp_core
// decimal text to 128-bit coefficient and power-of-ten exponent
// ----------------------------------------------------------------------------
module decimal_string_to_coeff_exp_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  dsce_pkg::in_item_t  in_data_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  output dsce_pkg::out_item_t out_data_o,
  input  logic                out_stall_i
);

  logic           jv, jready, qv, qpop;
  dsce_pkg::job_t jd, qd;

  dsce_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_data_i, .in_stall_o,
    .job_valid_o(jv), .job_o(jd), .job_ready_i(jready)
  );

  dsce_queue u_queue (
    .clk_i, .rst_ni, .push_i(jv), .push_data_i(jd), .ready_o(jready),
    .pop_valid_o(qv), .pop_data_o(qd), .pop_i(qpop)
  );

  dsce_back u_back (
    .clk_i, .rst_ni, .job_valid_i(qv), .job_i(qd), .job_pop_o(qpop),
    .out_valid_o, .out_data_o, .out_stall_i
  );

endmodule

### hw/rtl/dsce_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsce_checker
// port-level checks for the decimal string converter
// ----------------------------------------------------------------------------
module dsce_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input dsce_pkg::in_item_t  in_data_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input dsce_pkg::out_item_t out_data_o,
  input logic                out_stall_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status |-> out_data_o.kind == dsce_pkg::KIND_NORMAL &&
      out_data_o.coeff_high == 64'd0 && out_data_o.coeff_low == 64'd0 &&
      out_data_o.exponent == 32'd0 && !out_data_o.negative)
    else $error("error beat with nonzero fields");

  a_zero_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == dsce_pkg::KIND_NORMAL &&
      out_data_o.coeff_high == 64'd0 && out_data_o.coeff_low == 64'd0
      |-> !out_data_o.negative)
    else $error("negative zero coefficient");

  a_mid_nostall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_data_i.end_of_string |-> !in_stall_o)
    else $error("stall on a non-final character");

endmodule

bind decimal_string_to_coeff_exp_core dsce_checker u_checker (.*);
